// ===== design/lcs_pkg.sv =====
// Package for the lumped combustion step block: widths, codes and the decay entry function.
`default_nettype none
package lcs_pkg;
    localparam int unsigned EXP_ENTRIES_DEFAULT = 64;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BURN_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_TEMP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_PER_KG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OXY_RATIO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_CAP    = 3'd5;

    localparam logic [1:0] ST_REACTED = 2'd0;
    localparam logic [1:0] ST_GATED   = 2'd1;
    localparam logic [1:0] ST_LOADED  = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    localparam logic [63:0] DECAY_STEP_Q32 = 64'd3790295335;

    // Decay value exp(-k/8) in Q1.32 (entry 0 is 2^32), built by repeated rounding.
    // It is only evaluated for constant arguments while the table is elaborated.
    function automatic logic [32:0] decay_entry(input int unsigned k);
        logic [63:0] e;
        e = 64'h1_0000_0000;
        for (int unsigned j = 0; j < k; j++) begin
            e = (e * DECAY_STEP_Q32 + 64'h8000_0000) >> 32;
        end
        return e[32:0];
    endfunction
endpackage
`default_nettype wire

// ===== design/lumped_combustion_step.sv =====
// Lumped combustion step: one lump's masses and energy, updated by load and burn items.
// An item is taken only while the block is idle, and the next one only after the result
// transfer. A load is reported in the cycle after it is accepted. A burn step runs on one
// shared 64 by 40 shift-add multiplier (five products: activation gate, exponent, kinetic
// limit, oxygen use and heat) and a restoring divider for the oxygen limit; a reacting
// step also passes the interpolation, commit and result states, and a gated step goes
// from the gate product straight to the result. The result is held until it is taken.
`default_nettype none
module lumped_combustion_step #(
    parameter int unsigned EXP_TABLE_ENTRIES = lcs_pkg::EXP_ENTRIES_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [39:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic         s_tuser,   // op
    // fuel_load[31:0], oxygen_load[63:32], products_load[95:64],
    // energy_load[143:96], time_step[175:144]
    input  wire logic [175:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [1:0]        m_tuser,   // status
    // fuel_used[31:0], oxygen_used[63:32], products_made[95:64],
    // heat_released[143:96], fuel_now[175:144], oxygen_now[207:176],
    // products_now[239:208], energy_now[287:240]
    output logic [287:0]      m_tdata
);
    localparam int unsigned IW = $clog2(EXP_TABLE_ENTRIES + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_GATE = 4'd1, S_XMUL = 4'd2, S_INTERP = 4'd3,
                           S_KIN = 4'd4, S_DIV = 4'd5, S_OXY = 4'd6, S_HEAT = 4'd7,
                           S_DONE = 4'd8, S_OUT = 4'd9;

    logic [3:0]  state_reg;
    logic        burn_en_reg;
    logic [23:0] act_temp_reg;
    logic [31:0] rate_reg, heat_kg_reg, oxy_ratio_reg;
    logic [39:0] heat_cap_reg;
    logic [31:0] fuel_reg, oxy_reg, prod_reg;
    logic [47:0] energy_reg;
    logic [31:0] dt_reg;
    logic [31:0] used_reg, oxy_used_reg, made_reg, frac_reg;
    logic [47:0] heat_reg;
    logic        heat_sat_reg;
    logic [1:0]  status_reg;

    // Shared shift-add multiplier: acc += a << k when bit k of b is set.
    logic [127:0] acc_reg;
    logic [63:0]  mul_a_reg;
    logic [39:0]  mul_b_reg;
    logic [5:0]   cnt_reg;
    // Restoring divider state.
    logic [55:0]  quo_reg;
    logic [32:0]  rem_reg;
    logic [55:0]  quo_next;
    logic [32:0]  rem_next;
    logic [31:0]  used_clamped;

    logic [32:0]   decay_rom [0:EXP_TABLE_ENTRIES];
    logic [IW-1:0] idx;
    logic          beyond;
    logic [32:0]   e_hi, e_lo;
    logic [32:0]   ediff;
    logic [33:0]   rem_sh;

    for (genvar k = 0; k <= EXP_TABLE_ENTRIES; k++) begin : g_decay
        localparam logic [32:0] ENTRY = lcs_pkg::decay_entry(k);
        assign decay_rom[k] = ENTRY;
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tuser   = status_reg;
    assign m_tdata   = {energy_reg, prod_reg, oxy_reg, fuel_reg, heat_reg, made_reg,
                        oxy_used_reg, used_reg};

    assign beyond = (acc_reg[63:45] >= 19'(EXP_TABLE_ENTRIES));
    assign idx    = IW'(acc_reg[63:45]);
    always_comb begin
        e_hi = decay_rom[idx];
        e_lo = decay_rom[idx + IW'(1)];
        ediff = e_hi - e_lo;
    end
    assign rem_sh = {rem_reg, quo_reg[55]};

    // One divider step, and the fuel use limited by the finished oxygen quotient.
    always_comb begin
        if (rem_sh >= {2'b0, oxy_ratio_reg}) begin
            rem_next = 33'(rem_sh - {2'b0, oxy_ratio_reg});
            quo_next = {quo_reg[54:0], 1'b1};
        end else begin
            rem_next = rem_sh[32:0];
            quo_next = {quo_reg[54:0], 1'b0};
        end
        if (oxy_ratio_reg != 32'd0 && quo_next[55:32] == 24'd0 &&
            quo_next[31:0] < used_reg)
            used_clamped = quo_next[31:0];
        else
            used_clamped = used_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            burn_en_reg   <= 1'b0;
            act_temp_reg  <= '0;
            rate_reg      <= '0;
            heat_kg_reg   <= '0;
            oxy_ratio_reg <= 32'd16777216;
            heat_cap_reg  <= 40'd256;
            fuel_reg      <= '0;
            oxy_reg       <= '0;
            prod_reg      <= '0;
            energy_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    lcs_pkg::REG_BURN_ENABLE: burn_en_reg   <= cfg_data[0];
                    lcs_pkg::REG_ACT_TEMP:    act_temp_reg  <= cfg_data[23:0];
                    lcs_pkg::REG_RATE:        rate_reg      <= cfg_data[31:0];
                    lcs_pkg::REG_HEAT_PER_KG: heat_kg_reg   <= cfg_data[31:0];
                    lcs_pkg::REG_OXY_RATIO:   oxy_ratio_reg <= cfg_data[31:0];
                    lcs_pkg::REG_HEAT_CAP:    heat_cap_reg  <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    used_reg <= '0; oxy_used_reg <= '0; made_reg <= '0; heat_reg <= '0;
                    if (s_tvalid) begin
                        if (!s_tuser) begin
                            fuel_reg   <= s_tdata[31:0];
                            oxy_reg    <= s_tdata[63:32];
                            prod_reg   <= s_tdata[95:64];
                            energy_reg <= s_tdata[143:96];
                            status_reg <= lcs_pkg::ST_LOADED;
                            state_reg  <= S_OUT;
                        end else begin
                            dt_reg     <= s_tdata[175:144];
                            status_reg <= lcs_pkg::ST_GATED;
                            acc_reg    <= '0;
                            mul_a_reg  <= 64'(act_temp_reg);
                            mul_b_reg  <= heat_cap_reg;
                            cnt_reg    <= '0;
                            state_reg  <= S_GATE;
                        end
                    end
                end
                S_GATE, S_XMUL, S_KIN, S_OXY, S_HEAT: begin
                    // All 40 multiplier bits are in the accumulator once the count hits 40.
                    if (cnt_reg == 6'd40) begin
                        cnt_reg <= '0;
                        unique case (state_reg)
                            S_GATE: begin
                                if (!burn_en_reg || dt_reg == 32'd0 || fuel_reg == 32'd0 ||
                                    oxy_reg == 32'd0 || {8'd0, energy_reg, 8'd0} < acc_reg[63:0])
                                    state_reg <= S_OUT;
                                else begin
                                    acc_reg   <= '0;
                                    mul_a_reg <= 64'(rate_reg);
                                    mul_b_reg <= 40'(dt_reg);
                                    state_reg <= S_XMUL;
                                end
                            end
                            S_XMUL: state_reg <= S_INTERP;
                            S_KIN: begin
                                used_reg <= (acc_reg[63:32] < fuel_reg) ? acc_reg[63:32]
                                                                        : fuel_reg;
                                quo_reg  <= {oxy_reg, 24'd0};
                                rem_reg  <= '0;
                                state_reg <= S_DIV;
                            end
                            S_OXY: begin
                                oxy_used_reg <= acc_reg[55:24];
                                acc_reg   <= '0;
                                mul_a_reg <= 64'(used_reg);
                                mul_b_reg <= 40'(heat_kg_reg);
                                state_reg <= S_HEAT;
                            end
                            default: begin
                                heat_reg     <= (acc_reg[71:56] != 16'd0) ? '1 : acc_reg[55:8];
                                heat_sat_reg <= (acc_reg[71:56] != 16'd0);
                                state_reg    <= S_DONE;
                            end
                        endcase
                    end else begin
                        if (mul_b_reg[0]) acc_reg <= acc_reg + ({64'd0, mul_a_reg} << cnt_reg);
                        mul_b_reg <= mul_b_reg >> 1;
                        cnt_reg   <= cnt_reg + 6'd1;
                    end
                end
                S_INTERP: begin
                    // acc holds x; form f in Q1.32 then start fuel * f.
                    acc_reg   <= '0;
                    mul_a_reg <= 64'(fuel_reg);
                    mul_b_reg <= beyond ? 40'h1_0000_0000
                        : 40'(33'h1_0000_0000 - (e_hi - 33'((66'(ediff) * 66'(acc_reg[44:13])) >> 32)));
                    state_reg <= S_KIN;
                end
                S_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    if (cnt_reg == 6'd55) begin
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        used_reg  <= used_clamped;
                        mul_a_reg <= 64'(used_clamped);
                        mul_b_reg <= 40'(oxy_ratio_reg);
                        state_reg <= S_OXY;
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_DONE: begin : done_blk
                    logic [32:0] msum, psum;
                    logic [48:0] esum;
                    logic [31:0] mk;
                    logic        sat;
                    msum = {1'b0, used_reg} + {1'b0, oxy_used_reg};
                    sat  = msum[32] | heat_sat_reg;
                    mk   = msum[32] ? '1 : msum[31:0];
                    psum = {1'b0, prod_reg} + {1'b0, mk};
                    if (psum[32]) sat = 1'b1;
                    esum = {1'b0, energy_reg} + {1'b0, heat_reg};
                    if (esum[48]) sat = 1'b1;
                    made_reg     <= mk;
                    fuel_reg     <= fuel_reg - used_reg;
                    oxy_reg      <= oxy_reg - oxy_used_reg;
                    prod_reg     <= psum[32] ? '1 : psum[31:0];
                    energy_reg   <= esum[48] ? '1 : esum[47:0];
                    status_reg   <= sat ? lcs_pkg::ST_SAT : lcs_pkg::ST_REACTED;
                    state_reg    <= S_OUT;
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/lcs_checker.sv =====
// Port-level checker for the lumped combustion step block, bound into every instance of it.
`default_nettype none
module lcs_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [1:0]   m_tuser,
    input wire logic [287:0] m_tdata
);
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second item taken at once");
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == lcs_pkg::ST_LOADED |-> m_tdata[143:0] == '0)
        else $error("load reported consumption");
endmodule
bind lumped_combustion_step lcs_checker u_lcs_checker (.*);
`default_nettype wire
